FILE: src/glhf_pkg.sv
// Shared types and constants of the grid label hole filler.
package glhf_pkg;

	// Grid and label dimensions
	localparam int MAX_SIDE   = 32;
	localparam int LABEL_BITS = 10;
	localparam int SIDE_BITS  = 6;
	localparam int INDEX_BITS = 10;
	localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
	localparam int ADDR_BITS  = $clog2(DEPTH);
	localparam int POS_BITS   = $clog2(MAX_SIDE);

	// Neighbor count that fills a cell
	localparam logic [2:0] FILL_COUNT = 3'd3;

	// Register reset values
	localparam logic [SIDE_BITS-1:0]  SIDE_RESET   = SIDE_BITS'(20);
	localparam logic [LABEL_BITS-1:0] TARGET_RESET = '0;

	// Command codes
	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_RUN  = 2'd1;
	localparam logic [1:0] CMD_READ = 2'd2;

	// Register index, taken from paddr[2]
	localparam logic REG_SIDE   = 1'b0;
	localparam logic REG_TARGET = 1'b1;

	// Command word
	typedef struct packed {
		logic [1:0]            command;
		logic [INDEX_BITS-1:0] cell_index;
		logic [LABEL_BITS-1:0] cell_label;
	} cmd_word_t;

	// Response word
	typedef struct packed {
		logic [LABEL_BITS-1:0] read_label;
		logic                  run_done;
	} rsp_word_t;

endpackage

FILE: src/grid_label_hole_fill.sv
// Grid label hole filler: label store, fill sequencer and host ports.
//
// The block holds a square grid of labels (up to 32 by 32) in one RAM. A load word writes one
// cell. A read word's response word is presented from the next cycle on. A run word walks
// the grid in raster order, filling in place any cell that has at least three orthogonal
// neighbors holding the target label, or a corner cell whose two neighbors and diagonal all
// hold it; when side is below 2 there is no walk and the done word is presented directly.
// The pace is set by the single RAM read port: each cell needs six reads (itself, four
// neighbors, diagonal) and one decide/write step. No command word is taken during a run,
// nor while a response word is stalled.
module grid_label_hole_fill (
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  glhf_pkg::cmd_word_t       cmd_word,
	// Response channel
	output logic                      rsp_valid,
	input  logic                      rsp_stall,
	output glhf_pkg::rsp_word_t       rsp_word,
	// Register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTR,
		ST_LFT,
		ST_RGT,
		ST_UP,
		ST_DN,
		ST_DIAG,
		ST_EVAL
	} state_t;

	state_t state_q;

	// Registers
	logic [glhf_pkg::SIDE_BITS-1:0]  side_q;
	logic [glhf_pkg::LABEL_BITS-1:0] target_q;

	// Run position and neighbor flags
	logic [glhf_pkg::ADDR_BITS-1:0] ctr_q;
	logic [glhf_pkg::POS_BITS-1:0]  row_q;
	logic [glhf_pkg::POS_BITS-1:0]  col_q;
	logic                           ctr_hit_q;
	logic                           lft_hit_q;
	logic                           rgt_hit_q;
	logic                           up_hit_q;
	logic                           dn_hit_q;

	// Response registers
	logic rsp_valid_q;
	logic rsp_done_q;
	logic rsp_inside_q;

	// RAM ports
	logic                            ram_we;
	logic [glhf_pkg::ADDR_BITS-1:0]  ram_waddr;
	logic [glhf_pkg::LABEL_BITS-1:0] ram_wdata;
	logic                            ram_re;
	logic [glhf_pkg::ADDR_BITS-1:0]  ram_raddr;
	logic [glhf_pkg::LABEL_BITS-1:0] ram_rdata;

	logic                             cfg_write;
	logic [glhf_pkg::SIDE_BITS-1:0]   side_used;
	logic [2*glhf_pkg::SIDE_BITS-1:0] side_sq;
	logic                             cmd_inside;
	logic                             cmd_take;
	logic                             rsp_take;
	logic                             rsp_set;
	logic                             top;
	logic                             bot;
	logic                             lft;
	logic                             rgt;
	logic                             rd_hit;
	logic [glhf_pkg::ADDR_BITS-1:0]   side_addr;
	logic [glhf_pkg::ADDR_BITS-1:0]   diag_addr;
	logic [2:0]                       hit_cnt;
	logic                             corner_fill;
	logic                             fill;

	// Register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= glhf_pkg::SIDE_RESET;
			target_q <= glhf_pkg::TARGET_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				glhf_pkg::REG_SIDE:   side_q   <= pwdata[glhf_pkg::SIDE_BITS-1:0];
				glhf_pkg::REG_TARGET: target_q <= pwdata[glhf_pkg::LABEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			glhf_pkg::REG_SIDE:   prdata = 32'(side_q);
			glhf_pkg::REG_TARGET: prdata = 32'(target_q);
			default:              prdata = '0;
		endcase
	end

	// Grid geometry
	assign side_used  = (side_q > glhf_pkg::SIDE_BITS'(glhf_pkg::MAX_SIDE))
		? glhf_pkg::SIDE_BITS'(glhf_pkg::MAX_SIDE) : side_q;
	assign side_sq    = side_used * side_used;
	assign cmd_inside = (2*glhf_pkg::SIDE_BITS)'(cmd_word.cell_index) < side_sq;
	assign side_addr  = glhf_pkg::ADDR_BITS'(side_used);

	assign top = (row_q == '0);
	assign bot = (glhf_pkg::SIDE_BITS'(row_q) == side_used - glhf_pkg::SIDE_BITS'(1));
	assign lft = (col_q == '0);
	assign rgt = (glhf_pkg::SIDE_BITS'(col_q) == side_used - glhf_pkg::SIDE_BITS'(1));

	// Handshakes
	assign rsp_take  = rsp_valid_q && !rsp_stall;
	assign cmd_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_take  = cmd_valid && !cmd_stall;

	// A new response word is loaded this cycle
	assign rsp_set = (cmd_take && ((cmd_word.command == glhf_pkg::CMD_READ)
		|| ((cmd_word.command == glhf_pkg::CMD_RUN)
		&& (side_used < glhf_pkg::SIDE_BITS'(2)))))
		|| ((state_q == ST_EVAL) && rgt && bot);

	// Diagonal of a corner: one row inward, one column inward
	assign diag_addr = (top ? ctr_q + side_addr : ctr_q - side_addr)
		+ (lft ? glhf_pkg::ADDR_BITS'(1) : {glhf_pkg::ADDR_BITS{1'b1}});

	// Read address sequencing
	always_comb begin
		ram_re    = 1'b1;
		ram_raddr = ctr_q;
		unique case (state_q)
			ST_IDLE: begin
				ram_re    = cmd_take && (cmd_word.command == glhf_pkg::CMD_READ);
				ram_raddr = glhf_pkg::ADDR_BITS'(cmd_word.cell_index);
			end
			ST_CTR:  ram_raddr = ctr_q;
			ST_LFT:  ram_raddr = ctr_q - glhf_pkg::ADDR_BITS'(1);
			ST_RGT:  ram_raddr = ctr_q + glhf_pkg::ADDR_BITS'(1);
			ST_UP:   ram_raddr = ctr_q - side_addr;
			ST_DN:   ram_raddr = ctr_q + side_addr;
			ST_DIAG: ram_raddr = diag_addr;
			ST_EVAL: ram_re    = 1'b0;
			default: ram_re    = 1'b0;
		endcase
	end

	// Fill decision, evaluated when the diagonal label arrives
	assign rd_hit      = (ram_rdata == target_q);
	assign hit_cnt     = {2'b0, lft_hit_q} + {2'b0, rgt_hit_q} + {2'b0, up_hit_q}
		+ {2'b0, dn_hit_q};
	assign corner_fill = (top || bot) && (lft || rgt) && rd_hit
		&& (top ? dn_hit_q : up_hit_q) && (lft ? rgt_hit_q : lft_hit_q);
	assign fill        = !ctr_hit_q && ((hit_cnt >= glhf_pkg::FILL_COUNT) || corner_fill);

	// Write port: host loads when idle, fills during a run
	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_we    = cmd_take && (cmd_word.command == glhf_pkg::CMD_LOAD) && cmd_inside;
			ram_waddr = glhf_pkg::ADDR_BITS'(cmd_word.cell_index);
			ram_wdata = cmd_word.cell_label;
		end else begin
			ram_we    = (state_q == ST_EVAL) && fill;
			ram_waddr = ctr_q;
			ram_wdata = target_q;
		end
	end

	glhf_ram #(
		.WIDTH(glhf_pkg::LABEL_BITS),
		.DEPTH(glhf_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rsp_valid_q  <= 1'b0;
			rsp_done_q   <= 1'b0;
			rsp_inside_q <= 1'b0;
		end else begin
			if (rsp_take && !rsp_set) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (cmd_word.command)
							glhf_pkg::CMD_READ: begin
								rsp_valid_q  <= 1'b1;
								rsp_done_q   <= 1'b0;
								rsp_inside_q <= cmd_inside;
							end
							glhf_pkg::CMD_RUN: begin
								if (side_used < glhf_pkg::SIDE_BITS'(2)) begin
									rsp_valid_q <= 1'b1;
									rsp_done_q  <= 1'b1;
								end else begin
									state_q <= ST_CTR;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CTR:  state_q <= ST_LFT;
				ST_LFT:  state_q <= ST_RGT;
				ST_RGT:  state_q <= ST_UP;
				ST_UP:   state_q <= ST_DN;
				ST_DN:   state_q <= ST_DIAG;
				ST_DIAG: state_q <= ST_EVAL;
				ST_EVAL: begin
					if (rgt && bot) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
						rsp_done_q  <= 1'b1;
					end else begin
						state_q <= ST_CTR;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Run position and captured neighbor hits
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ctr_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end
			ST_LFT:  ctr_hit_q <= rd_hit;
			ST_RGT:  lft_hit_q <= !lft && rd_hit;
			ST_UP:   rgt_hit_q <= !rgt && rd_hit;
			ST_DN:   up_hit_q  <= !top && rd_hit;
			ST_DIAG: dn_hit_q  <= !bot && rd_hit;
			ST_EVAL: begin
				ctr_q <= ctr_q + glhf_pkg::ADDR_BITS'(1);
				if (rgt) begin
					col_q <= '0;
					row_q <= row_q + glhf_pkg::POS_BITS'(1);
				end else begin
					col_q <= col_q + glhf_pkg::POS_BITS'(1);
				end
			end
			default: ;
		endcase
	end

	// Response word
	assign rsp_valid           = rsp_valid_q;
	assign rsp_word.run_done   = rsp_done_q;
	assign rsp_word.read_label = (!rsp_done_q && rsp_inside_q) ? ram_rdata : '0;

`ifndef SYNTHESIS
	// No command word is taken while a run walks the grid
	a_no_cmd_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> cmd_stall)
		else $error("command taken during a run");

	// A run writes the store only in its decide cycle
	a_run_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != ST_IDLE) |-> (state_q == ST_EVAL))
		else $error("store written outside decide cycle");

	// A taken read is answered in the next cycle with read data
	a_read_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_take && cmd_word.command == glhf_pkg::CMD_READ) |=> (rsp_valid && !rsp_word.run_done))
		else $error("read not answered");

	// The done word carries a zero label
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_word.run_done) |-> (rsp_word.read_label == '0))
		else $error("done word with nonzero label");
`endif

endmodule

FILE: src/glhf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module glhf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: dv/glhf_scoreboard.sv
// Scoreboard for the grid label hole filler: mirrors the label grid and checks response words.
`timescale 1ns / 100ps

module glhf_scoreboard (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	input  logic                cmd_stall,
	input  glhf_pkg::cmd_word_t cmd_word,
	input  logic                rsp_valid,
	input  logic                rsp_stall,
	input  glhf_pkg::rsp_word_t rsp_word,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  mismatch_count,
	output int                  words_owed
);

	// Mirror of the label grid and of the two registers
	logic [glhf_pkg::LABEL_BITS-1:0] label_mirror [glhf_pkg::DEPTH];
	logic [glhf_pkg::SIDE_BITS-1:0]  side_reg;
	logic [glhf_pkg::LABEL_BITS-1:0] fill_label;
	glhf_pkg::rsp_word_t             owed_words [$];

	initial begin
		mismatch_count = 0;
		words_owed     = 0;
		side_reg       = glhf_pkg::SIDE_RESET;
		fill_label     = glhf_pkg::TARGET_RESET;
	end

	// Sides above the grid limit clamp to it
	function automatic int grid_span();
		return (side_reg > glhf_pkg::MAX_SIDE) ? glhf_pkg::MAX_SIDE : int'(side_reg);
	endfunction

	function automatic bit holds_fill(int n, int r, int c);
		return label_mirror[r * n + c] == fill_label;
	endfunction

	// One raster pass, in place: filled cells count for every later cell
	task automatic fill_pass();
		int n;
		int cnt;
		int vr;
		int hc;
		bit on_top;
		bit on_bot;
		bit on_lft;
		bit on_rgt;
		n = grid_span();
		if (n < 2)
			return;
		for (int r = 0; r < n; r++) begin
			for (int c = 0; c < n; c++) begin
				if (holds_fill(n, r, c))
					continue;
				on_top = (r == 0);
				on_bot = (r == n - 1);
				on_lft = (c == 0);
				on_rgt = (c == n - 1);
				cnt = 0;
				if (!on_lft && holds_fill(n, r, c - 1)) cnt++;
				if (!on_rgt && holds_fill(n, r, c + 1)) cnt++;
				if (!on_top && holds_fill(n, r - 1, c)) cnt++;
				if (!on_bot && holds_fill(n, r + 1, c)) cnt++;
				if (cnt >= glhf_pkg::FILL_COUNT) begin
					label_mirror[r * n + c] = fill_label;
					continue;
				end
				// corner: both neighbors and the diagonal must hold the target
				if ((on_top || on_bot) && (on_lft || on_rgt)) begin
					vr = on_top ? r + 1 : r - 1;
					hc = on_lft ? c + 1 : c - 1;
					if (holds_fill(n, vr, c) && holds_fill(n, r, hc) && holds_fill(n, vr, hc))
						label_mirror[r * n + c] = fill_label;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		int n;
		glhf_pkg::rsp_word_t want;
		if (!arst_n) begin
			side_reg   = glhf_pkg::SIDE_RESET;
			fill_label = glhf_pkg::TARGET_RESET;
			owed_words.delete();
		end else begin
			// register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == glhf_pkg::REG_TARGET)
					fill_label = pwdata[glhf_pkg::LABEL_BITS-1:0];
				else
					side_reg = pwdata[glhf_pkg::SIDE_BITS-1:0];
			end
			// response words against the oldest expectation
			if (rsp_valid && !rsp_stall) begin
				if (owed_words.size() == 0) begin
					$error("unexpected word: read_label %0d, run_done %0d",
						rsp_word.read_label, rsp_word.run_done);
					mismatch_count++;
				end else begin
					want = owed_words.pop_front();
					if (rsp_word.read_label !== want.read_label) begin
						$error("read_label: expected %0d, got %0d",
							want.read_label, rsp_word.read_label);
						mismatch_count++;
					end
					if (rsp_word.run_done !== want.run_done) begin
						$error("run_done: expected %0d, got %0d",
							want.run_done, rsp_word.run_done);
						mismatch_count++;
					end
				end
			end
			// command words
			if (cmd_valid && !cmd_stall) begin
				n = grid_span();
				case (cmd_word.command)
					glhf_pkg::CMD_LOAD: begin
						if (cmd_word.cell_index < n * n)
							label_mirror[cmd_word.cell_index] = cmd_word.cell_label;
					end
					glhf_pkg::CMD_RUN: begin
						fill_pass();
						want.read_label = '0;
						want.run_done   = 1'b1;
						owed_words.push_back(want);
					end
					glhf_pkg::CMD_READ: begin
						want.read_label = (cmd_word.cell_index < n * n) ?
							label_mirror[cmd_word.cell_index] : '0;
						want.run_done   = 1'b0;
						owed_words.push_back(want);
					end
					default: ;
				endcase
			end
		end
		words_owed = owed_words.size();
	end

endmodule

FILE: dv/tb_grid_label_hole_fill.sv
// Testbench top of the grid label hole filler: stimulus, stall patterns, watchdog, verdict.
`timescale 1ns / 100ps

module tb_grid_label_hole_fill;

	localparam int RANDOM_ITEMS = 1050;
	localparam int QUIET_CYCLES = 8;
	localparam int TAIL_CYCLES  = 20;
	localparam int STALL_LIMIT  = 40000;
	localparam int BIG_CELLS    = 256;

	// Unused command code, dropped by the block
	localparam logic [1:0] CMD_NONE    = 2'd3;
	localparam logic [2:0] ADDR_SIDE   = {glhf_pkg::REG_SIDE, 2'b00};
	localparam logic [2:0] ADDR_TARGET = {glhf_pkg::REG_TARGET, 2'b00};

	logic                clk;
	logic                arst_n;
	logic                cmd_valid;
	logic                cmd_stall;
	glhf_pkg::cmd_word_t cmd_word;
	logic                rsp_valid;
	logic                rsp_stall;
	glhf_pkg::rsp_word_t rsp_word;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	int mismatch_count;
	int words_owed;
	int quiet_cycles;
	int send_idle_pct;
	int rsp_stall_pct;
	int counted_words;
	int side_now;
	logic [glhf_pkg::LABEL_BITS-1:0] target_now;
	bit cell_loaded [glhf_pkg::DEPTH];

	grid_label_hole_fill uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	glhf_scoreboard scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.cmd_word       (cmd_word),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.rsp_word       (rsp_word),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.mismatch_count (mismatch_count),
		.words_owed     (words_owed)
	);

	// 4 ns clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Receiver stall pattern
	always @(negedge clk)
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);

	// Watchdog: cycles with no accepted word and no register access
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int span_of(int s);
		return (s > glhf_pkg::MAX_SIDE) ? glhf_pkg::MAX_SIDE : s;
	endfunction

	// Mostly the target, so holes get surrounded
	function automatic logic [glhf_pkg::LABEL_BITS-1:0] pick_label();
		int r;
		r = $urandom_range(0, 99);
		if (r < 62)
			return target_now;
		if (r < 80)
			return target_now ^ glhf_pkg::LABEL_BITS'($urandom_range(1, 3));
		return glhf_pkg::LABEL_BITS'($urandom_range(0, 1023));
	endfunction

	// Mostly small grids, a few large ones and the extremes
	function automatic int pick_side();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom_range(0, 1);
		if (r < 70)
			return $urandom_range(2, 6);
		if (r < 90)
			return $urandom_range(7, 10);
		if (r < 96)
			return $urandom_range(11, 16);
		return ($urandom_range(0, 1) != 0) ? 63 : glhf_pkg::MAX_SIDE;
	endfunction

	function automatic logic [glhf_pkg::LABEL_BITS-1:0] pick_target();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return '1;
		return glhf_pkg::LABEL_BITS'($urandom_range(0, 1023));
	endfunction

	// Present one word, idling at random, and hold it until taken
	task automatic send_word(input logic [1:0] op, input int idx, input int lab);
		glhf_pkg::cmd_word_t w;
		w.command    = op;
		w.cell_index = glhf_pkg::INDEX_BITS'(idx);
		w.cell_label = glhf_pkg::LABEL_BITS'(lab);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word  <= w;
		do
			@(posedge clk);
		while (cmd_stall);
		counted_words++;
	endtask

	// Hold off until every owed word has come back and the block is quiet
	task automatic drain();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (words_owed != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		drain();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_side(input int s);
		write_reg(ADDR_SIDE, 32'(s));
		side_now = s;
	endtask

	task automatic set_target(input logic [glhf_pkg::LABEL_BITS-1:0] t);
		write_reg(ADDR_TARGET, 32'(t));
		target_now = t;
	endtask

	task automatic load_cell(input int idx, input int lab);
		int n;
		n = span_of(side_now);
		send_word(glhf_pkg::CMD_LOAD, idx, lab);
		if (idx < n * n)
			cell_loaded[idx] = 1'b1;
	endtask

	task automatic read_cell(input int idx);
		send_word(glhf_pkg::CMD_READ, idx, $urandom_range(0, 1023));
	endtask

	task automatic run_fill();
		send_word(glhf_pkg::CMD_RUN, $urandom_range(0, 1023), $urandom_range(0, 1023));
	endtask

	// Stray words: unused command, off-grid access, read of a loaded cell
	task automatic stray_word(input int cells);
		int r;
		int idx;
		r = $urandom_range(0, 3);
		if (r == 0) begin
			send_word(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023));
		end else if (cells < glhf_pkg::DEPTH && r == 1) begin
			send_word(glhf_pkg::CMD_LOAD, $urandom_range(cells, glhf_pkg::DEPTH - 1),
				$urandom_range(0, 1023));
		end else if (cells < glhf_pkg::DEPTH && r == 2) begin
			read_cell($urandom_range(cells, glhf_pkg::DEPTH - 1));
		end else if (cells > 0) begin
			idx = $urandom_range(0, cells - 1);
			if (cell_loaded[idx])
				read_cell(idx);
		end
	endtask

	// Load a whole grid, run it, read it back; near the end of a budget use a small grid
	task automatic fill_round(input int left);
		int n;
		int cells;
		int idx;
		if ($urandom_range(0, 99) < 50)
			set_side(pick_side());
		if ($urandom_range(0, 99) < 30)
			set_target(pick_target());
		n = span_of(side_now);
		cells = n * n;
		if (cells <= BIG_CELLS && n > 2 && 3 * cells + 8 > left) begin
			set_side(2);
			n = 2;
			cells = 4;
		end
		if (cells > BIG_CELLS) begin
			// full-size grid: scattered loads and reads of loaded cells only
			repeat (24) begin
				idx = $urandom_range(0, cells - 1);
				if (cell_loaded[idx] && $urandom_range(0, 1) != 0)
					read_cell(idx);
				else
					load_cell(idx, pick_label());
			end
			return;
		end
		for (int i = 0; i < cells; i++) begin
			if ($urandom_range(0, 99) < 8)
				stray_word(cells);
			load_cell(i, pick_label());
		end
		if (cells > 0 && $urandom_range(0, 99) < 25) begin
			repeat (cells / 4 + 1) load_cell($urandom_range(0, cells - 1), pick_label());
		end
		run_fill();
		if ($urandom_range(0, 99) < 25)
			run_fill();
		for (int i = 0; i < cells; i++) begin
			if ($urandom_range(0, 99) < 6)
				stray_word(cells);
			read_cell(i);
		end
		if (cells < glhf_pkg::DEPTH)
			read_cell($urandom_range(cells, glhf_pkg::DEPTH - 1));
	endtask

	initial begin
		int base;
		arst_n        = 1'b0;
		cmd_valid     = 1'b0;
		cmd_word      = '0;
		rsp_stall     = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		quiet_cycles  = 0;
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		counted_words = 0;
		side_now      = int'(glhf_pkg::SIDE_RESET);
		target_now    = glhf_pkg::TARGET_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// 2x2 corner fill: top-left differs, both neighbors and the diagonal hold it
		set_side(2);
		set_target('1);
		load_cell(0, 0);
		load_cell(1, 1023);
		load_cell(2, 1023);
		load_cell(3, 1023);
		run_fill();
		read_cell(0);
		read_cell(3);
		// off-grid load is dropped, off-grid read returns zero, unused command is dropped
		send_word(glhf_pkg::CMD_LOAD, glhf_pkg::DEPTH - 1, 10'h155);
		read_cell(glhf_pkg::DEPTH - 1);
		send_word(CMD_NONE, 10'h3FF, 10'h3FF);

		// 3x3 in-place fill: the center fills, then its right neighbor sees it
		set_side(3);
		set_target(10'h155);
		for (int i = 0; i < 9; i++)
			load_cell(i, (i == 4 || i == 5) ? 10'h2AA : 10'h155);
		run_fill();
		read_cell(4);
		read_cell(5);

		// oversized side clamps to the full grid
		set_side(63);
		load_cell(glhf_pkg::DEPTH - 1, 10'h3FF);
		read_cell(glhf_pkg::DEPTH - 1);

		// random rounds, one idle pattern per quarter
		base = counted_words;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1) ? 69 : (phase == 3) ? 16 : 0;
			rsp_stall_pct = (phase == 2) ? 69 : (phase == 3) ? 16 : 0;
			while (counted_words < base + (phase + 1) * RANDOM_ITEMS / 4)
				fill_round(base + (phase + 1) * RANDOM_ITEMS / 4 - counted_words);
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: files.f
src/glhf_pkg.sv
src/glhf_ram.sv
src/grid_label_hole_fill.sv
dv/glhf_scoreboard.sv
dv/tb_grid_label_hole_fill.sv
